/* rtl/core/pds_pkg.sv */
package pds_pkg;

	// Status codes
	localparam logic [2:0] ST_OK     = 3'd0;
	localparam logic [2:0] ST_MODE   = 3'd1;
	localparam logic [2:0] ST_SOURCE = 3'd2;
	localparam logic [2:0] ST_HEAD   = 3'd3;
	localparam logic [2:0] ST_NONE   = 3'd4;

	// PLL limits and constants
	localparam logic [36:0] VCO_MIN   = 37'd256000;
	localparam logic [36:0] VCO_MAX   = 37'd1300000;
	localparam logic [24:0] REF_KHZ   = 25'd27000;
	localparam logic [24:0] FB_DEN    = 25'd54000;
	// floor(2^32 / 54000): quotient estimate is exact or one low
	localparam logic [16:0] FB_RECIP  = 17'd79536;
	localparam logic [8:0]  FB_MIN    = 9'd2;
	localparam logic [8:0]  FB_MAX    = 9'd257;
	localparam logic [32:0] PPM_MUL   = 33'd1000000;
	localparam logic [32:0] MILLI_MUL = 33'd1000;
	localparam logic [29:0] FRAC_MUL  = 30'd1000;

	typedef struct packed {
		logic [31:0] target_khz;
		logic        mode_accepted;
		logic        source_verified;
		logic        head_verified;
		logic        head_known;
	} pds_req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] requested_echo;
		logic [22:0] actual_khz;
		logic [31:0] deviation_ppm;
		logic [23:0] vco_khz;
		logic [8:0]  feedback_div;
		logic [3:0]  reference_div;
		logic [4:0]  post_div;
	} pds_res_t;

	// Per-item control carried alongside the lanes
	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] req;
	} pds_info_t;

	// One divider candidate
	typedef struct packed {
		logic        ok;
		logic [22:0] err;
		logic [22:0] ach;
		logic [23:0] vco;
		logic [8:0]  fb;
		logic [4:0]  rdiv;
		logic [1:0]  pidx;
	} pds_cand_t;

	// Keep the better of two candidates: least error, then smaller
	// reference divider, then smaller post divider
	function automatic pds_cand_t pds_pick(pds_cand_t a, pds_cand_t b);
		logic a_wins;
		priority if (!a.ok)
			a_wins = 1'b0;
		else if (!b.ok)
			a_wins = 1'b1;
		else if (a.err != b.err)
			a_wins = (a.err < b.err);
		else if (a.rdiv != b.rdiv)
			a_wins = (a.rdiv < b.rdiv);
		else
			a_wins = (a.pidx <= b.pidx);
		return a_wins ? a : b;
	endfunction

endpackage

/* rtl/core/pll_divider_search_unit.sv */
// Channel  Signals                    Beat taken when
// request  req_valid, req_stall, req  req_valid && !req_stall
// result   res_valid, res_stall, res  res_valid && !res_stall
//
// One beat enters per cycle unless a stalled result holds the pipeline. Every
// post/reference divider pair has a lane of its own, a registered tree picks
// the winner, and a radix-2 divider works out the error in ppm one quotient
// bit per stage, with a scaling stage between integer and fraction bits.
// Reset clears the valid bits only. A stalled result freezes the whole
// pipeline, so req_stall rises while a result waits under res_stall.
module pll_divider_search_unit #(
	parameter int REF_DIV_MAX = 10
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  pds_pkg::pds_req_t  req,
	output logic               res_valid,
	input  logic               res_stall,
	output pds_pkg::pds_res_t  res
);
	import pds_pkg::*;

	localparam int NL    = 4 * REF_DIV_MAX;
	localparam int LV    = $clog2(NL);
	localparam int NP    = 1 << LV;
	localparam int NPIPE = 7 + LV;

	logic        adv;
	logic [2:0]  entry_status;

	logic [NPIPE-1:0] stg_v_q;
	pds_info_t        stg_info_q [NPIPE];

	pds_cand_t leaf    [NP];
	pds_cand_t tree_lhs [NP-1];
	pds_cand_t tree_rhs [NP-1];
	pds_cand_t tree_q  [NP-1];

	pds_info_t root_info;
	pds_cand_t root;
	logic      found;
	pds_res_t  base;

	logic        dv;
	logic [8:0]  dq1;
	logic [9:0]  dq2;
	pds_res_t    dpay;
	logic [32:0] ppm_w;
	logic [31:0] ppm;
	pds_res_t    res_d;

	logic     res_valid_q;
	pds_res_t res_q;

	// Move everything whenever the output slot is free or being taken
	assign adv       = !res_valid_q || !res_stall;
	assign req_stall = !adv;

	// Check preconditions in order
	always_comb begin
		priority if (!req.mode_accepted)
			entry_status = ST_MODE;
		else if (!req.source_verified)
			entry_status = ST_SOURCE;
		else if (!req.head_verified || !req.head_known)
			entry_status = ST_HEAD;
		else
			entry_status = ST_OK;
	end

	// Carry valid bits along the lanes and the tree
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stg_v_q <= '0;
		end else if (adv) begin
			stg_v_q <= {stg_v_q[NPIPE-2:0], req_valid};
		end
	end

	// Carry status and request beside them
	always_ff @(posedge clk) begin
		if (adv) begin
			stg_info_q[0] <= '{status: entry_status, req: req.target_khz};
			for (int i = 1; i < NPIPE; i++)
				stg_info_q[i] <= stg_info_q[i-1];
		end
	end

	// One lane for each post and reference divider
	genvar gp, gr, gl, gi;
	generate
		for (gp = 0; gp < 4; gp++) begin : g_post
			for (gr = 1; gr <= REF_DIV_MAX; gr++) begin : g_ref
				pds_lane #(
					.P(gp),
					.R(gr)
				) u_lane (
					.clk    (clk),
					.adv    (adv),
					.req_s1 (stg_info_q[0].req),
					.req_s6 (stg_info_q[5].req),
					.cand   (leaf[gp * REF_DIV_MAX + gr - 1])
				);
			end
		end
		for (gl = NL; gl < NP; gl++) begin : g_pad
			assign leaf[gl] = '0;
		end
		// Wire tree children: deepest nodes take the lanes
		for (gi = 0; gi < NP - 1; gi++) begin : g_node
			if (2 * gi + 1 >= NP - 1) begin : g_leaf
				assign tree_lhs[gi] = leaf[2 * gi + 1 - (NP - 1)];
				assign tree_rhs[gi] = leaf[2 * gi + 2 - (NP - 1)];
			end else begin : g_inner
				assign tree_lhs[gi] = tree_q[2 * gi + 1];
				assign tree_rhs[gi] = tree_q[2 * gi + 2];
			end
		end
	endgenerate

	// Pick the best candidate one tree level per stage
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < NP - 1; i++)
				tree_q[i] <= pds_pick(tree_lhs[i], tree_rhs[i]);
		end
	end

	// Build the result, cleared where the request failed or no divider fits
	assign root_info = stg_info_q[NPIPE-1];
	assign root      = tree_q[0];
	assign found     = (root_info.status == ST_OK) && root.ok;

	always_comb begin
		base                = '0;
		base.requested_echo = root_info.req;
		if (root_info.status != ST_OK)
			base.status = root_info.status;
		else if (!root.ok)
			base.status = ST_NONE;
		else
			base.status = ST_OK;
		if (found) begin
			base.actual_khz    = root.ach;
			base.vco_khz       = root.vco;
			base.feedback_div  = root.fb;
			base.reference_div = root.rdiv[3:0];
			base.post_div      = 5'd2 << root.pidx;
		end
	end

	pds_ppm u_ppm (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (stg_v_q[NPIPE-1]),
		.num       (root.err),
		.den       (root_info.req[19:0]),
		.pay_in    (base),
		.out_valid (dv),
		.q1        (dq1),
		.q2        (dq2),
		.pay_out   (dpay)
	);

	// Assemble ppm and saturate
	assign ppm_w = 33'(dq1) * PPM_MUL + 33'(dq2) * MILLI_MUL;
	assign ppm   = ppm_w[32] ? '1 : ppm_w[31:0];

	// Merge the ppm figure into the payload
	always_comb begin
		res_d               = dpay;
		res_d.deviation_ppm = (dpay.status == ST_OK) ? ppm : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= dv;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res_d;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

`ifndef SYNTHESIS
	a_fb_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res.status == ST_OK) |->
			(res.feedback_div >= FB_MIN) && (res.feedback_div <= FB_MAX))
		else $error("feedback divider out of range on ok result");

	a_fail_clear: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res.status != ST_OK) |->
			(res.post_div == '0) && (res.vco_khz == '0) && (res.deviation_ppm == '0))
		else $error("failed result carries divider data");

	a_ach_vco: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res.status == ST_OK) |->
			((res.post_div == 5'd2) && (res.actual_khz == res.vco_khz[23:1])) ||
			((res.post_div == 5'd4) && (res.actual_khz == {1'b0, res.vco_khz[23:2]})) ||
			((res.post_div == 5'd8) && (res.actual_khz == {2'b0, res.vco_khz[23:3]})) ||
			((res.post_div == 5'd16) && (res.actual_khz == {3'b0, res.vco_khz[23:4]})))
		else $error("achieved clock does not match vco and post divider");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> res_valid && res_stall)
		else $error("request stalled without a blocked result");
`endif

endmodule

/* rtl/core/pds_lane.sv */
module pds_lane #(
	parameter int P = 0,
	parameter int R = 1
) (
	input  logic                clk,
	input  logic                adv,
	input  logic [31:0]         req_s1,
	input  logic [31:0]         req_s6,
	output pds_pkg::pds_cand_t  cand
);
	import pds_pkg::*;

	// ceil(2^29 / R) gives an exact floor quotient for 24-bit numerators
	localparam logic [29:0] RECIP = 30'(((64'd1 << 29) + R - 1) / R);
	localparam logic [4:0]  RV    = 5'(R);

	logic [36:0] vco;
	logic        vco_ok;
	logic [24:0] x_n;
	logic [41:0] xm;
	logic [24:0] rem;
	logic [8:0]  fb_n;
	logic [53:0] prod;
	logic [22:0] ach;
	logic [22:0] req23;

	logic [24:0] x_s2;
	logic        ok_s2;
	logic [24:0] x_s3;
	logic [8:0]  q0_s3;
	logic        ok_s3;
	logic [8:0]  fb_s4;
	logic        ok_s4;
	logic [23:0] num_s5;
	logic [8:0]  fb_s5;
	logic        ok_s5;
	logic [23:0] avco_s6;
	logic [8:0]  fb_s6;
	logic        ok_s6;
	pds_cand_t   cand_s7;

	// Scale the request by the post divider and round the feedback numerator
	assign vco    = {5'd0, req_s1} << (P + 1);
	assign vco_ok = (vco >= VCO_MIN) && (vco <= VCO_MAX);
	assign x_n    = 25'(vco[20:0]) * 25'(RV) + REF_KHZ;

	// Estimate the feedback quotient by reciprocal
	assign xm = 42'(x_s2) * 42'(FB_RECIP);

	// Correct the estimate by one where the remainder is still too large
	assign rem  = x_s3 - 25'(q0_s3) * FB_DEN;
	assign fb_n = q0_s3 + 9'(rem >= FB_DEN);

	// Divide the achieved VCO numerator by the reference divider
	assign prod = 54'(num_s5) * 54'(RECIP);

	// Error against the request
	assign ach   = 23'(avco_s6 >> (P + 1));
	assign req23 = req_s6[22:0];

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s2    <= x_n;
			ok_s2   <= vco_ok;
			x_s3    <= x_s2;
			q0_s3   <= xm[40:32];
			ok_s3   <= ok_s2;
			fb_s4   <= fb_n;
			ok_s4   <= ok_s3 && (fb_n >= FB_MIN) && (fb_n <= FB_MAX);
			num_s5  <= 24'(fb_s4) * 24'(FB_DEN);
			fb_s5   <= fb_s4;
			ok_s5   <= ok_s4;
			avco_s6 <= prod[52:29];
			fb_s6   <= fb_s5;
			ok_s6   <= ok_s5;
			cand_s7.ok   <= ok_s6;
			cand_s7.err  <= (ach >= req23) ? (ach - req23) : (req23 - ach);
			cand_s7.ach  <= ach;
			cand_s7.vco  <= avco_s6;
			cand_s7.fb   <= fb_s6;
			cand_s7.rdiv <= RV;
			cand_s7.pidx <= 2'(P);
		end
	end

	assign cand = cand_s7;

endmodule

/* rtl/core/pds_ppm.sv */
module pds_ppm (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  logic               in_valid,
	input  logic [22:0]        num,
	input  logic [19:0]        den,
	input  pds_pkg::pds_res_t  pay_in,
	output logic               out_valid,
	output logic [8:0]         q1,
	output logic [9:0]         q2,
	output pds_pkg::pds_res_t  pay_out
);
	import pds_pkg::*;

	// Nine integer quotient steps, one scaling step, ten fraction steps
	localparam int NS = 20;

	logic [NS-1:0] v_q;
	logic [29:0]   rem_q [NS];
	logic [19:0]   den_q [NS];
	logic [8:0]    q1_q  [NS];
	logic [9:0]    q2_q  [NS];
	pds_res_t      pay_q [NS];

	logic [NS-1:0] cur_v;
	logic [29:0]   cur_rem [NS];
	logic [19:0]   cur_den [NS];
	logic [8:0]    cur_q1  [NS];
	logic [9:0]    cur_q2  [NS];
	pds_res_t      cur_pay [NS];
	logic [29:0]   nxt_rem [NS];
	logic [8:0]    nxt_q1  [NS];
	logic [9:0]    nxt_q2  [NS];

	genvar s;
	generate
		for (s = 0; s < NS; s++) begin : g_stage
			logic [29:0] sh;
			logic        take;
			// Feed each step from the one before
			if (s == 0) begin : g_head
				assign cur_v[s]   = in_valid;
				assign cur_rem[s] = 30'(num);
				assign cur_den[s] = den;
				assign cur_q1[s]  = '0;
				assign cur_q2[s]  = '0;
				assign cur_pay[s] = pay_in;
			end else begin : g_body
				assign cur_v[s]   = v_q[s-1];
				assign cur_rem[s] = rem_q[s-1];
				assign cur_den[s] = den_q[s-1];
				assign cur_q1[s]  = q1_q[s-1];
				assign cur_q2[s]  = q2_q[s-1];
				assign cur_pay[s] = pay_q[s-1];
			end
			// One restoring step per stage, but for the scaling stage
			if (s < 9) begin : g_int
				assign sh          = 30'(cur_den[s]) << (8 - s);
				assign take        = cur_rem[s] >= sh;
				assign nxt_rem[s]  = take ? (cur_rem[s] - sh) : cur_rem[s];
				assign nxt_q1[s]   = cur_q1[s] | (9'(take) << (8 - s));
				assign nxt_q2[s]   = cur_q2[s];
			end else if (s == 9) begin : g_scale
				assign sh          = '0;
				assign take        = 1'b0;
				assign nxt_rem[s]  = cur_rem[s] * FRAC_MUL + sh + 30'(take);
				assign nxt_q1[s]   = cur_q1[s];
				assign nxt_q2[s]   = cur_q2[s];
			end else begin : g_frac
				assign sh          = 30'(cur_den[s]) << (19 - s);
				assign take        = cur_rem[s] >= sh;
				assign nxt_rem[s]  = take ? (cur_rem[s] - sh) : cur_rem[s];
				assign nxt_q1[s]   = cur_q1[s];
				assign nxt_q2[s]   = cur_q2[s] | (10'(take) << (19 - s));
			end
		end
	endgenerate

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (adv) begin
			v_q <= cur_v;
		end
	end

	// Advance data
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < NS; i++) begin
				rem_q[i] <= nxt_rem[i];
				den_q[i] <= cur_den[i];
				q1_q[i]  <= nxt_q1[i];
				q2_q[i]  <= nxt_q2[i];
				pay_q[i] <= cur_pay[i];
			end
		end
	end

	assign out_valid = v_q[NS-1];
	assign q1        = q1_q[NS-1];
	assign q2        = q2_q[NS-1];
	assign pay_out   = pay_q[NS-1];

endmodule
